### rtl/core/dmc_pkg.sv
// Shared widths, defaults and the statistics control type of the
// direct-mapped read cache. No dependencies.
package dmc_pkg;

    localparam int ADDR_W     = 10;
    localparam int DATA_W     = 8;
    localparam int LINE_OUT_W = 2;
    localparam int TAG_OUT_W  = 5;
    localparam int MISS_W     = 16;
    localparam int TIME_W     = 32;

    localparam int MEM_BYTES_DEF  = 1024;
    localparam int NUM_LINES_DEF  = 4;
    localparam int LINE_BYTES_DEF = 8;

    localparam logic [TIME_W-1:0] LOOKUP_COST = TIME_W'(10);

    // one lookup's worth of bookkeeping; a miss also bumps the miss count
    typedef struct packed {
        logic count_miss;
        logic count_lookup;
    } stats_ctl_t;

endpackage

### rtl/core/dmc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/dmc_stats.sv
// Saturating miss and elapsed-time counters of the cache.
// Depends on dmc_pkg.
module dmc_stats (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dmc_pkg::stats_ctl_t         ctl,
    output logic [dmc_pkg::MISS_W-1:0]  miss_next,
    output logic [dmc_pkg::TIME_W-1:0]  time_next
);
    import dmc_pkg::*;

    logic [MISS_W-1:0] miss_reg;
    logic [TIME_W-1:0] time_reg;
    logic              add_time;

    // miss and plain lookup never come in the same cycle
    assign add_time = ctl.count_miss || ctl.count_lookup;

    always_comb
    begin
        miss_next = miss_reg;
        if (ctl.count_miss && (miss_reg != '1))
        begin
            miss_next = miss_reg + MISS_W'(1);
        end
        time_next = time_reg;
        if (add_time)
        begin
            if (time_reg > ('1 - LOOKUP_COST))
            begin
                time_next = '1;
            end
            else
            begin
                time_next = time_reg + LOOKUP_COST;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_reg <= '0;
            time_reg <= '0;
        end
        else
        begin
            miss_reg <= miss_next;
            time_reg <= time_next;
        end
    end

endmodule

### rtl/core/direct_mapped_cache_read.sv
// Direct-mapped read cache in front of a byte-wide backing memory.
// Depends on dmc_pkg, dmc_ram and dmc_stats.
//
// A transaction with req_type 0 stores write_data into the backing memory at
// address and gives no result. A transaction with req_type 1 looks up the
// line picked by the address (offset in the low log2(LINE_BYTES) bits, line
// above it, tag above that) and returns one result: hit, the byte, line and
// tag, and the saturating miss count and elapsed time (10 per lookup, so 20
// on a miss) including this access. On a hit the accept cycle reads the tag
// and line-data RAMs, the next compares and loads the output register. On a
// miss the refill streams the block one byte per cycle through the single
// read port of the backing RAM into the line-data RAM, then sets tag and
// valid. Loads do not update cached lines. The output register lets a new
// transaction enter while a result still waits on out_stall; a result that
// finds the register full waits in the block, which stalls its input
// meanwhile. No clearing pass after reset: line valid bits are flip-flops.
// MEM_BYTES, NUM_LINES and LINE_BYTES must be powers of two; addresses wrap
// modulo MEM_BYTES.
module direct_mapped_cache_read #(
    parameter int MEM_BYTES  = dmc_pkg::MEM_BYTES_DEF,
    parameter int NUM_LINES  = dmc_pkg::NUM_LINES_DEF,
    parameter int LINE_BYTES = dmc_pkg::LINE_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [dmc_pkg::ADDR_W-1:0]      address,
    input  logic [dmc_pkg::DATA_W-1:0]      write_data,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            hit,
    output logic [dmc_pkg::DATA_W-1:0]      read_data,
    output logic [dmc_pkg::LINE_OUT_W-1:0]  line_index,
    output logic [dmc_pkg::TAG_OUT_W-1:0]   tag_value,
    output logic [dmc_pkg::MISS_W-1:0]      miss_total,
    output logic [dmc_pkg::TIME_W-1:0]      elapsed_time
);
    import dmc_pkg::*;

    // address split
    localparam int OFF_W   = $clog2(LINE_BYTES);
    localparam int LINE_W  = $clog2(NUM_LINES);
    localparam int LIDX_W  = (LINE_W > 0) ? LINE_W : 1;
    localparam int TAG_RAW = ADDR_W - OFF_W - LINE_W;
    localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int MEM_AW  = $clog2(MEM_BYTES);
    localparam int DAW     = $clog2(NUM_LINES * LINE_BYTES);
    localparam int CNT_W   = OFF_W + 1;

    localparam logic [ADDR_W-1:0] MEM_MASK  = ADDR_W'(MEM_BYTES - 1);
    localparam logic [ADDR_W-1:0] LINE_MASK = ADDR_W'(NUM_LINES - 1);
    localparam logic [ADDR_W-1:0] OFF_MASK  = ADDR_W'(LINE_BYTES - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_REFILL = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic              in_acc;
    logic [ADDR_W-1:0] in_addr_w;
    logic [ADDR_W-1:0] in_line_full;

    // request held while it is served
    logic [ADDR_W-1:0] req_addr_reg, req_addr_next;
    logic [ADDR_W-1:0] req_line_full;
    logic [ADDR_W-1:0] req_tag_full;
    logic [OFF_W-1:0]  req_off;
    logic [LIDX_W-1:0] req_line;

    logic [NUM_LINES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DATA_W-1:0]    cap_reg, cap_next;
    logic                 hit_reg, hit_next;

    // RAM ports
    logic              mem_we;
    logic [MEM_AW-1:0] mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    logic              tag_we;
    logic [TAG_W-1:0]  tag_rdata;
    logic              line_we;
    logic [DAW-1:0]    line_waddr;
    logic [DAW-1:0]    line_raddr;
    logic [DATA_W-1:0] line_rdata;

    logic              lookup_hit;
    logic [OFF_W-1:0]  wr_off;

    // result path
    logic              fin_valid;
    logic              fin_hit;
    logic [DATA_W-1:0] fin_data;
    logic              out_free;
    logic              out_load;
    logic              out_valid_reg, out_valid_next;

    stats_ctl_t        st_ctl;
    logic [MISS_W-1:0] miss_next;
    logic [TIME_W-1:0] time_next;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    assign in_addr_w    = address & MEM_MASK;
    assign in_line_full = (in_addr_w >> OFF_W) & LINE_MASK;

    assign req_line_full = (req_addr_reg >> OFF_W) & LINE_MASK;
    assign req_tag_full  = req_addr_reg >> (OFF_W + LINE_W);
    assign req_off       = OFF_W'(req_addr_reg & OFF_MASK);
    assign req_line      = LIDX_W'(req_line_full);

    // backing memory: loads write at accept, refill reads block bytes in order
    assign mem_we    = in_acc && !req_type;
    assign mem_raddr = MEM_AW'({req_addr_reg[ADDR_W-1:OFF_W], cnt_reg[OFF_W-1:0]});

    dmc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (MEM_AW'(in_addr_w)),
        .wdata (write_data),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // tag store: read at accept, written when a refill completes
    dmc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_LINES)
    ) u_tag (
        .clk   (clk),
        .we    (tag_we),
        .waddr (req_line),
        .wdata (TAG_W'(req_tag_full)),
        .raddr (LIDX_W'(in_line_full)),
        .rdata (tag_rdata)
    );

    // line data: byte read at accept, refill writes one byte per cycle
    assign wr_off     = OFF_W'(cnt_reg - CNT_W'(1));
    assign line_waddr = (DAW'(req_line_full) << OFF_W) | DAW'(wr_off);
    assign line_raddr = (DAW'(in_line_full) << OFF_W) | DAW'(in_addr_w & OFF_MASK);

    dmc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_LINES * LINE_BYTES)
    ) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (mem_rdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    assign lookup_hit = valid_reg[req_line] && (tag_rdata == TAG_W'(req_tag_full));

    // a result is ready on a hit in lookup or when parked in finish
    assign fin_valid = ((state_reg == ST_LOOKUP) && lookup_hit) || (state_reg == ST_FINISH);
    assign fin_hit   = (state_reg == ST_LOOKUP) ? 1'b1 : hit_reg;
    assign fin_data  = (state_reg == ST_LOOKUP) ? line_rdata : cap_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = fin_valid && out_free;

    assign st_ctl.count_miss   = (state_reg == ST_LOOKUP) && !lookup_hit;
    assign st_ctl.count_lookup = out_load;

    dmc_stats u_stats (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (st_ctl),
        .miss_next (miss_next),
        .time_next (time_next)
    );

    always_comb
    begin
        state_next    = state_reg;
        req_addr_next = req_addr_reg;
        valid_next    = valid_reg;
        cnt_next      = cnt_reg;
        cap_next      = cap_reg;
        hit_next      = hit_reg;
        tag_we        = 1'b0;
        line_we       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && req_type)
                begin
                    req_addr_next = in_addr_w;
                    state_next    = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!lookup_hit)
                begin
                    hit_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_REFILL;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    hit_next   = 1'b1;
                    cap_next   = line_rdata;
                    state_next = ST_FINISH;
                end
            end
            ST_REFILL:
            begin
                // read for byte cnt issued now, byte cnt-1 lands now
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg != '0)
                begin
                    line_we = 1'b1;
                    if (wr_off == req_off)
                    begin
                        cap_next = mem_rdata;
                    end
                end
                if (cnt_reg == CNT_W'(LINE_BYTES))
                begin
                    tag_we               = 1'b1;
                    valid_next[req_line] = 1'b1;
                    state_next           = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_addr_reg <= req_addr_next;
        cap_reg      <= cap_next;
        if (out_load)
        begin
            hit          <= fin_hit;
            read_data    <= fin_data;
            line_index   <= LINE_OUT_W'(req_line_full);
            tag_value    <= TAG_OUT_W'(req_tag_full);
            miss_total   <= miss_next;
            elapsed_time <= time_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/core/dmc_checker.sv
// Port-level checks of the direct-mapped read cache, bound to its top level.
// Depends on dmc_pkg and direct_mapped_cache_read.
module dmc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            req_type,
    input  logic [dmc_pkg::ADDR_W-1:0]      address,
    input  logic [dmc_pkg::DATA_W-1:0]      write_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            hit,
    input  logic [dmc_pkg::DATA_W-1:0]      read_data,
    input  logic [dmc_pkg::LINE_OUT_W-1:0]  line_index,
    input  logic [dmc_pkg::TAG_OUT_W-1:0]   tag_value,
    input  logic [dmc_pkg::MISS_W-1:0]      miss_total,
    input  logic [dmc_pkg::TIME_W-1:0]      elapsed_time
);
    import dmc_pkg::*;

    logic              out_acc;
    logic [MISS_W-1:0] last_miss_reg;
    logic [TIME_W-1:0] last_time_reg;

    assign out_acc = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_miss_reg <= '0;
            last_time_reg <= '0;
        end
        else if (out_acc)
        begin
            last_miss_reg <= miss_total;
            last_time_reg <= elapsed_time;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(miss_total))
        else $error("stalled result changed");

    // a read transaction always needs a lookup cycle after accept
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && req_type |=> in_stall)
        else $error("input not stalled during lookup");

    // results come out only after the block was busy
    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a lookup");

    // a hit leaves the miss count alone, a miss moves it by one or saturates
    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (hit && (miss_total == last_miss_reg)) ||
                    (!hit && ((miss_total == last_miss_reg + MISS_W'(1)) ||
                              (miss_total == '1))))
        else $error("miss count inconsistent with hit");

    // elapsed time never goes backward
    a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (elapsed_time > last_time_reg) || (elapsed_time == '1))
        else $error("elapsed time did not advance");

endmodule

bind direct_mapped_cache_read dmc_checker u_dmc_checker (.*);
